/* rtl/core/cmsb_pkg.sv */
// Shared types and constants for the clipped mirrored sprite blitter.
`default_nettype none

package cmsb_pkg;

   // Coordinate width: a signed corner plus a region offset
   localparam int COORD_W = 15;
   // Image dimension register width
   localparam int DIM_W   = 13;
   // Pixel address width
   localparam int ADDR_W  = 24;
   localparam int PIX_W   = 8;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_SRC_ROW_PIXELS = 2'd0;
   localparam logic [1:0] CSR_DST_ROW_PIXELS = 2'd1;
   localparam logic [1:0] CSR_DST_ROWS       = 2'd2;

   // Item kinds carried on req_tuser
   localparam logic ACTION_SETUP = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   // Image geometry from the csr registers
   typedef struct packed {
      logic [DIM_W-1:0] src_row_pixels;
      logic [DIM_W-1:0] dst_row_pixels;
      logic [DIM_W-1:0] dst_rows;
   } geometry_type;

   // One pixel with its source and target coordinates
   typedef struct packed {
      logic signed [COORD_W-1:0] src_y;
      logic signed [COORD_W-1:0] src_x;
      logic signed [COORD_W-1:0] dst_y;
      logic signed [COORD_W-1:0] dst_x;
      logic [PIX_W-1:0]          gray;
      logic [PIX_W-1:0]          alpha;
      logic                      last;
   } pixel_coord_type;

   // One finished result
   typedef struct packed {
      logic              write_enable;
      logic [ADDR_W-1:0] target_address;
      logic [ADDR_W-1:0] source_address;
      logic [PIX_W-1:0]  gray;
      logic [PIX_W-1:0]  alpha;
      logic              last;
   } blit_result_type;

endpackage

`default_nettype wire

/* rtl/core/clipped_mirrored_sprite_blit.sv */
// Top level of the clipped mirrored sprite blitter.
`default_nettype none

// Sprite blitter for gray-plus-alpha pixels. A setup transfer (req_tuser 0)
// latches the source corner, target corner, region size and mirror flag; pixel
// transfers (req_tuser 1) then follow in raster order, and each gives one
// result with the source and target pixel indices (byte offsets are twice
// these). Pixels outside the target image or with alpha zero come out with
// write_enable low; pixels with no blit running give no result. The block
// takes one transfer per clock while the pipeline can advance (rsp_tready high
// or a stage empty): a pixel passes a coordinate register and then an address
// register (one 13x13 multiply-add per address), and with rsp_tready low the
// result and rsp_tvalid are held in the address register.
module clipped_mirrored_sprite_blit
   import cmsb_pkg::*;
#(
   parameter int MAX_SPRITE_SIDE = 256
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [11:0] src_left, [23:12] src_top, [37:24] dst_left, [51:38] dst_top,
   // [60:52] region_width, [69:61] region_height, [70] mirror,
   // [78:71] gray_in, [86:79] alpha_in, [87] zero
   input  wire logic [87:0] req_tdata,
   // [0] action
   input  wire logic        req_tuser,
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] write_enable, [24:1] target_address, [48:25] source_address,
   // [56:49] gray_out, [64:57] alpha_out, [71:65] zero
   output logic [71:0]      rsp_tdata,
   output logic             rsp_tlast,
   // configuration writes
   input  wire logic        csr_wen,
   input  wire logic [1:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   localparam int CNT_W  = (MAX_SPRITE_SIDE > 1) ? $clog2(MAX_SPRITE_SIDE) : 1;
   localparam int SIDE_W = 9;

   // Request fields
   logic [11:0]              f_src_left;
   logic [11:0]              f_src_top;
   logic signed [13:0]       f_dst_left;
   logic signed [13:0]       f_dst_top;
   logic [SIDE_W-1:0]        f_width;
   logic [SIDE_W-1:0]        f_height;
   logic                     f_mirror;
   logic [PIX_W-1:0]         f_gray;
   logic [PIX_W-1:0]         f_alpha;

   assign f_src_left = req_tdata[11:0];
   assign f_src_top  = req_tdata[23:12];
   assign f_dst_left = req_tdata[37:24];
   assign f_dst_top  = req_tdata[51:38];
   assign f_width    = req_tdata[60:52];
   assign f_height   = req_tdata[69:61];
   assign f_mirror   = req_tdata[70];
   assign f_gray     = req_tdata[78:71];
   assign f_alpha    = req_tdata[86:79];

   // Configuration registers
   geometry_type geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.src_row_pixels <= DIM_W'(1024);
         geom_ff.dst_row_pixels <= DIM_W'(2048);
         geom_ff.dst_rows       <= DIM_W'(2048);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SRC_ROW_PIXELS: geom_ff.src_row_pixels <= csr_wdata;
            CSR_DST_ROW_PIXELS: geom_ff.dst_row_pixels <= csr_wdata;
            CSR_DST_ROWS:       geom_ff.dst_rows       <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Pipeline handshake: address stage, then coordinate stage, then input
   logic coord_valid_ff;
   logic rsp_valid_ff;
   logic rsp_advance;
   logic coord_advance;
   logic req_xfer;
   logic setup_xfer;
   logic pixel_xfer;

   assign rsp_advance   = !rsp_valid_ff || rsp_tready;
   assign coord_advance = !coord_valid_ff || rsp_advance;
   assign req_tready    = coord_advance;
   assign req_xfer      = req_tvalid && req_tready;
   assign setup_xfer    = req_xfer && (req_tuser == ACTION_SETUP);

   // Blit state
   logic                      active_ff;
   logic [CNT_W-1:0]          col_ff;
   logic [CNT_W-1:0]          row_ff;
   logic [11:0]               src_left_ff;
   logic [11:0]               src_top_ff;
   logic signed [13:0]        dst_left_ff;
   logic signed [13:0]        dst_top_ff;
   logic [CNT_W-1:0]          width_m1_ff;
   logic [CNT_W-1:0]          height_m1_ff;
   logic                      mirror_ff;

   assign pixel_xfer = req_xfer && (req_tuser == ACTION_PIXEL) && active_ff;

   // Clamp a region side to 1..MAX_SPRITE_SIDE and return side minus one
   function automatic logic [CNT_W-1:0] side_m1(input logic [SIDE_W-1:0] side);
      logic [10:0] s;
      s = (side == '0) ? 11'd1 : 11'(side);
      if (s > 11'(MAX_SPRITE_SIDE)) begin
         s = 11'(MAX_SPRITE_SIDE);
      end
      side_m1 = CNT_W'(s - 11'd1);
   endfunction

   logic              col_end;
   logic              row_end;
   logic              is_last;
   logic [CNT_W-1:0]  col_off;

   assign col_end = col_ff == width_m1_ff;
   assign row_end = row_ff == height_m1_ff;
   assign is_last = col_end && row_end;
   assign col_off = mirror_ff ? (width_m1_ff - col_ff) : col_ff;

   // Latch setup, step the raster counters on each pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         src_left_ff  <= '0;
         src_top_ff   <= '0;
         dst_left_ff  <= '0;
         dst_top_ff   <= '0;
         width_m1_ff  <= '0;
         height_m1_ff <= '0;
         mirror_ff    <= 1'b0;
      end else if (setup_xfer) begin
         active_ff    <= 1'b1;
         col_ff       <= '0;
         row_ff       <= '0;
         src_left_ff  <= f_src_left;
         src_top_ff   <= f_src_top;
         dst_left_ff  <= f_dst_left;
         dst_top_ff   <= f_dst_top;
         width_m1_ff  <= side_m1(f_width);
         height_m1_ff <= side_m1(f_height);
         mirror_ff    <= f_mirror;
      end else if (pixel_xfer) begin
         if (is_last) begin
            active_ff <= 1'b0;
            col_ff    <= '0;
            row_ff    <= '0;
         end else if (col_end) begin
            col_ff <= '0;
            row_ff <= row_ff + CNT_W'(1);
         end else begin
            col_ff <= col_ff + CNT_W'(1);
         end
      end
   end

   // Coordinate stage
   pixel_coord_type coord_in;
   pixel_coord_type coord_ff;

   always_comb begin
      coord_in.src_y = COORD_W'(src_top_ff) + COORD_W'(row_ff);
      coord_in.src_x = COORD_W'(src_left_ff) + COORD_W'(col_ff);
      coord_in.dst_y = COORD_W'(dst_top_ff) + COORD_W'(row_ff);
      coord_in.dst_x = COORD_W'(dst_left_ff) + COORD_W'(col_off);
      coord_in.gray  = f_gray;
      coord_in.alpha = f_alpha;
      coord_in.last  = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_valid_ff <= 1'b0;
      end else if (coord_advance) begin
         coord_valid_ff <= pixel_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (pixel_xfer) begin
         coord_ff <= coord_in;
      end
   end

   // Address stage and result register
   blit_result_type result;
   logic            addr_load;

   assign addr_load = rsp_advance && coord_valid_ff;

   cmsb_addr u_addr (
      .clock  (clock),
      .load   (addr_load),
      .coord  (coord_ff),
      .geom   (geom_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_advance) begin
         rsp_valid_ff <= coord_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = result.last;
   assign rsp_tdata  = {7'd0, result.alpha, result.gray, result.source_address,
                        result.target_address, result.write_enable};

endmodule

`default_nettype wire

/* rtl/core/cmsb_addr.sv */
// Address stage: clips the target coordinate and forms both pixel addresses.
`default_nettype none

module cmsb_addr
   import cmsb_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            load,
   input  wire pixel_coord_type coord,
   input  wire geometry_type    geom,
   output blit_result_type      result
);

   logic [2*DIM_W-1:0] src_prod;
   logic [2*DIM_W-1:0] dst_prod;
   logic               x_inside;
   logic               y_inside;
   logic               in_target;
   logic               opaque;
   blit_result_type    result_in;
   blit_result_type    result_ff;

   // Clip against the target image; negative coordinates are outside
   assign x_inside  = !coord.dst_x[COORD_W-1] &&
                      (coord.dst_x[COORD_W-2:0] < (COORD_W-1)'(geom.dst_row_pixels));
   assign y_inside  = !coord.dst_y[COORD_W-1] &&
                      (coord.dst_y[COORD_W-2:0] < (COORD_W-1)'(geom.dst_rows));
   assign in_target = x_inside && y_inside;
   assign opaque    = coord.alpha != '0;

   // Row times stride plus column; rows and columns in range fit DIM_W bits
   assign src_prod = (2*DIM_W)'(coord.src_y[DIM_W-1:0]) * (2*DIM_W)'(geom.src_row_pixels)
                   + (2*DIM_W)'(coord.src_x[DIM_W-1:0]);
   assign dst_prod = (2*DIM_W)'(coord.dst_y[DIM_W-1:0]) * (2*DIM_W)'(geom.dst_row_pixels)
                   + (2*DIM_W)'(coord.dst_x[DIM_W-1:0]);

   always_comb begin
      result_in.write_enable   = in_target && opaque;
      result_in.target_address = in_target ? dst_prod[ADDR_W-1:0] : '0;
      result_in.source_address = src_prod[ADDR_W-1:0];
      result_in.gray           = (in_target && opaque) ? coord.gray : '0;
      result_in.alpha          = (in_target && opaque) ? coord.alpha : '0;
      result_in.last           = coord.last;
   end

   // Hold the result until the next load
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
